// ===== sv/sspan_pkg.sv =====
// sspan_pkg: shared types and constants of the stock span block
// payload structs, stack entry layout, controller states and command/status bundles
// no dependencies
package sspan_pkg;

  localparam int MaxItems  = 1024;
  localparam int CntW      = $clog2(MaxItems + 1);
  localparam int AddrW     = $clog2(MaxItems);
  localparam int PriceW    = 32;
  localparam int SpanW     = 11;

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic              start_req;
  } in_t;

  typedef struct packed {
    logic [SpanW-1:0] span;
    logic             overflow;
  } out_t;

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [AddrW-1:0]  position;
  } entry_t;

  typedef enum logic {
    StIdle,
    StCmp
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pop;
    logic push;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ovf;
    logic top_le;
    logic out_free;
  } status_t;

endpackage

// ===== sv/sspan_ctrl.sv =====
// sspan_ctrl: controller state machine of the stock span block
// sequences accept, compare-and-pop, push and result load
// depends on sspan_pkg
module sspan_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sspan_pkg::status_t  status_i,
  output sspan_pkg::cmd_t     cmd_o,
  output logic                in_stall_o
);

  sspan_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sspan_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sspan_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = sspan_pkg::StCmp;
        end
      end
      sspan_pkg::StCmp: begin
        if (status_i.ovf) begin
          if (status_i.out_free) begin
            state_d = sspan_pkg::StIdle;
          end
        end else if (!status_i.top_le && status_i.out_free) begin
          state_d = sspan_pkg::StIdle;
        end
      end
      default: state_d = sspan_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      sspan_pkg::StIdle: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      sspan_pkg::StCmp: begin
        if (status_i.ovf) begin
          cmd_o.out_load = status_i.out_free;
        end else if (status_i.top_le) begin
          cmd_o.pop = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.out_load = 1'b1;
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

// ===== sv/sspan_dp.sv =====
// sspan_dp: datapath of the stock span block
// stack memory, stack count, position counter, span arithmetic and output register
// depends on sspan_pkg
module sspan_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sspan_pkg::in_t      in_data_i,
  input  logic                out_stall_i,
  input  sspan_pkg::cmd_t     cmd_i,
  output sspan_pkg::status_t  status_o,
  output logic                out_valid_o,
  output sspan_pkg::out_t     out_data_o
);

  localparam int CntW  = sspan_pkg::CntW;
  localparam int AddrW = sspan_pkg::AddrW;

  sspan_pkg::entry_t mem [sspan_pkg::MaxItems];
  sspan_pkg::entry_t rd_q;

  logic [sspan_pkg::PriceW-1:0] price_q;
  logic [CntW-1:0]              count_q;
  logic [CntW-1:0]              pos_q;
  logic                         out_valid_q;
  sspan_pkg::out_t              out_q;

  logic [CntW-1:0]  rd_idx;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  logic [CntW-1:0]  span_full;
  logic             ovf;

  // read the entry that will be on top next cycle, unless this cycle pushes
  assign rd_idx = cmd_i.pop ? CntW'(count_q - CntW'(2)) : CntW'(count_q - CntW'(1));
  assign raddr  = rd_idx[AddrW-1:0];
  assign waddr  = count_q[AddrW-1:0];

  assign ovf = (pos_q == CntW'(sspan_pkg::MaxItems));

  always_comb begin
    if (count_q == '0) begin
      span_full = CntW'(pos_q + CntW'(1));
    end else begin
      span_full = CntW'(pos_q - {{(CntW-AddrW){1'b0}}, rd_q.position});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[waddr] <= '{price: price_q, position: pos_q[AddrW-1:0]};
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      price_q <= in_data_i.price;
    end
    if (cmd_i.out_load) begin
      if (ovf) begin
        out_q <= '{span: '0, overflow: 1'b1};
      end else begin
        out_q <= '{span: sspan_pkg::SpanW'(span_full), overflow: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && in_data_i.start_req) begin
        count_q <= '0;
        pos_q   <= '0;
      end else if (cmd_i.pop) begin
        count_q <= CntW'(count_q - CntW'(1));
      end else if (cmd_i.push) begin
        count_q <= CntW'(count_q + CntW'(1));
        pos_q   <= CntW'(pos_q + CntW'(1));
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.ovf      = ovf;
  assign status_o.top_le   = (count_q != '0) && (rd_q.price <= price_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/stock_span_monotonic_stack.sv =====
// stock_span_monotonic_stack: top level, span of each price back to the previous greater one
// flow: an item is accepted in idle, then the compare state pops the stack entries it covers,
// then pushes it and loads its result, waiting while the output register stays stalled
// the input stalls until the item is done, so items do not overlap; each entry pops at most once
// reset: stack empty, position 0, no result pending; stack memory itself is not cleared
// depends on sspan_pkg, sspan_ctrl, sspan_dp
module stock_span_monotonic_stack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sspan_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sspan_pkg::out_t  out_data_o
);

  // command and status between controller and datapath
  sspan_pkg::cmd_t    cmd;
  sspan_pkg::status_t status;

  // controller: idle takes an item, compare state pops while the top price is not greater,
  // then pushes and loads the result once the output register is free; on overflow only loads
  // the pop loop does one compare against the registered stack-top read per cycle
  sspan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath: stack memory with registered top read, counters and output register,
  // so a new item is taken while the previous result still waits downstream
  sspan_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
